// File: hw/rtl/grf_pkg.sv
`default_nettype none

package grf_pkg;

  // grid geometry
  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 64;
  localparam int CELL_TOTAL = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W     = $clog2(CELL_TOTAL);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);

  // field widths fixed by the interface
  localparam int DIM_W     = 7;
  localparam int START_W   = 6;
  localparam int KIND_W    = 2;
  localparam int COUNT_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // cell codes
  localparam logic [KIND_W-1:0] KIND_BLOCKED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OPEN    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MUST    = 2'd2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH  = 2'd0,
    CFG_MAP_HEIGHT = 2'd1,
    CFG_START_COL  = 2'd2,
    CFG_START_ROW  = 2'd3
  } cfg_idx_e;

  // neighbor probe order
  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_UP    = 2'd3
  } dir_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_LOAD,
    ST_START,
    ST_POP,
    ST_POP_WAIT,
    ST_PROBE,
    ST_CHECK,
    ST_SCAN,
    ST_SCAN_END,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0] cell_kind;
    logic              last_cell;
  } cell_in_t;

  typedef struct packed {
    logic               all_reachable;
    logic [COUNT_W-1:0] unreached_count;
  } result_t;

  typedef struct packed {
    logic [DIM_W-1:0]   map_width;
    logic [DIM_W-1:0]   map_height;
    logic [START_W-1:0] start_col;
    logic [START_W-1:0] start_row;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } coord_t;

  localparam int STACK_W = $bits(coord_t);

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic start;
    logic pop;
    logic pop_latch;
    logic probe;
    logic nb_adv;
    logic check;
    logic scan_issue;
    logic publish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic sp_zero;
    logic nb_inb;
    logic nb_last;
    logic scan_last;
    logic out_full;
  } status_t;

  // size register clamped to 1..lim
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > lim) r = lim;
    return r;
  endfunction

  // row-major store index r * w + c
  function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c,
                                                   input logic [DIM_W-1:0] w);
    logic [ROW_W+DIM_W-1:0] prod;
    logic [ROW_W+DIM_W-1:0] sum;
    prod = (ROW_W+DIM_W)'(r) * (ROW_W+DIM_W)'(w);
    sum  = prod + (ROW_W+DIM_W)'(c);
    return sum[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/grf_ram.sv
`default_nettype none

module grf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/grf_ctrl.sv
`default_nettype none

module grf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_last_i,
  input  wire grf_pkg::status_t  status_i,
  output logic                   in_ready_o,
  output grf_pkg::cmd_t          cmd_o
);

  import grf_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) state_d = ST_START;
        end
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        state_d     = ST_POP;
      end
      ST_POP: begin
        if (status_i.sp_zero) begin
          state_d = ST_SCAN;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: begin
        cmd_o.pop_latch = 1'b1;
        state_d         = ST_PROBE;
      end
      ST_PROBE: begin
        if (status_i.nb_inb) begin
          cmd_o.probe = 1'b1;
          state_d     = ST_CHECK;
        end else if (status_i.nb_last) begin
          state_d = ST_POP;
        end else begin
          cmd_o.nb_adv = 1'b1;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (status_i.nb_last) begin
          state_d = ST_POP;
        end else begin
          cmd_o.nb_adv = 1'b1;
          state_d      = ST_PROBE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (status_i.scan_last) state_d = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!status_i.out_full) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/grf_dp.sv
`default_nettype none

module grf_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire grf_pkg::cmd_t     cmd_i,
  input  wire grf_pkg::cfg_t     cfg_i,
  input  wire grf_pkg::cell_in_t in_data_i,
  input  wire logic              out_ready_i,
  output grf_pkg::status_t       status_o,
  output logic                   out_valid_o,
  output grf_pkg::result_t       out_data_o
);

  import grf_pkg::*;

  logic [DIM_W-1:0]   w_q, h_q, w_eff, h_eff;
  logic [2*DIM_W-1:0] area_m1_q;
  logic [ADDR_W-1:0]  load_addr_q;
  logic [ADDR_W:0]    sp_q;
  logic [ADDR_W:0]    sweep_q;
  coord_t             cur_q, nb_c, pr_q;
  dir_e               nb_q;
  logic               nb_inb;
  logic [ADDR_W-1:0]  nb_idx, pr_idx_q, start_idx, scan_idx_q;
  logic               scan_vld_q;
  logic               start_ok;
  logic               push;
  logic [COUNT_W-1:0] missed_q;
  logic               out_valid_q;
  result_t            out_q;

  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [KIND_W-1:0]  cell_rd;
  logic               vis_rd;
  logic               vis_we, vis_wd;
  logic [ADDR_W-1:0]  vis_wa;
  logic               stk_we;
  logic [ADDR_W-1:0]  stk_wa, stk_ra;
  coord_t             stk_wd, stk_rd;

  // effective grid size and start cell
  assign w_eff     = clamp_dim(cfg_i.map_width, DIM_W'(MAX_COLS));
  assign h_eff     = clamp_dim(cfg_i.map_height, DIM_W'(MAX_ROWS));
  assign start_ok  = (DIM_W'(cfg_i.start_col) < w_eff) && (DIM_W'(cfg_i.start_row) < h_eff);
  assign start_idx = cell_index(ROW_W'(cfg_i.start_row), COL_W'(cfg_i.start_col), w_eff);

  // neighbor coordinates and bounds
  always_comb begin
    nb_c   = cur_q;
    nb_inb = 1'b0;
    case (nb_q)
      DIR_RIGHT: begin
        nb_inb     = (DIM_W'(cur_q.col) + DIM_W'(1)) < w_q;
        nb_c.col   = cur_q.col + COL_W'(1);
      end
      DIR_LEFT: begin
        nb_inb     = (cur_q.col != '0);
        nb_c.col   = cur_q.col - COL_W'(1);
      end
      DIR_DOWN: begin
        nb_inb     = (DIM_W'(cur_q.row) + DIM_W'(1)) < h_q;
        nb_c.row   = cur_q.row + ROW_W'(1);
      end
      DIR_UP: begin
        nb_inb     = (cur_q.row != '0);
        nb_c.row   = cur_q.row - ROW_W'(1);
      end
      default: begin
        nb_inb = 1'b0;
      end
    endcase
  end

  assign nb_idx = cell_index(nb_c.row, nb_c.col, w_q);

  // shared read address for cell store and visited map
  assign rd_en   = cmd_i.probe | cmd_i.scan_issue;
  assign rd_addr = cmd_i.probe ? nb_idx : sweep_q[ADDR_W-1:0];

  assign push = cmd_i.check && !vis_rd && !sp_q[ADDR_W] &&
                (cell_rd == KIND_OPEN || cell_rd == KIND_MUST);

  // visited map write source
  always_comb begin
    vis_we = 1'b0;
    vis_wa = sweep_q[ADDR_W-1:0];
    vis_wd = 1'b0;
    if (cmd_i.clr_step) begin
      vis_we = 1'b1;
    end else if (cmd_i.start) begin
      vis_we = start_ok;
      vis_wa = start_idx;
      vis_wd = 1'b1;
    end else if (push) begin
      vis_we = 1'b1;
      vis_wa = pr_idx_q;
      vis_wd = 1'b1;
    end else if (scan_vld_q) begin
      vis_we = 1'b1;
      vis_wa = scan_idx_q;
    end
  end

  // fill stack ports
  assign stk_we = (cmd_i.start && start_ok) || push;
  assign stk_wa = cmd_i.start ? '0 : sp_q[ADDR_W-1:0];
  assign stk_wd = cmd_i.start ? coord_t'({ROW_W'(cfg_i.start_row), COL_W'(cfg_i.start_col)})
                              : pr_q;
  assign stk_ra = sp_q[ADDR_W-1:0] - ADDR_W'(1);

  grf_ram #(.WIDTH(KIND_W), .DEPTH(CELL_TOTAL)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (load_addr_q),
    .wdata_i (in_data_i.cell_kind),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (cell_rd)
  );

  grf_ram #(.WIDTH(1), .DEPTH(CELL_TOTAL)) u_vis_ram (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_wa),
    .wdata_i (vis_wd),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (vis_rd)
  );

  grf_ram #(.WIDTH(STACK_W), .DEPTH(CELL_TOTAL)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_wa),
    .wdata_i (stk_wd),
    .re_i    (cmd_i.pop),
    .raddr_i (stk_ra),
    .rdata_o (stk_rd)
  );

  // control counters and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_addr_q <= '0;
      sp_q        <= '0;
      sweep_q     <= '0;
      nb_q        <= DIR_RIGHT;
      scan_vld_q  <= 1'b0;
      missed_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // load address wraps past the last store entry
      if (cmd_i.publish) begin
        load_addr_q <= '0;
      end else if (cmd_i.load) begin
        if (load_addr_q == ADDR_W'(CELL_TOTAL - 1)) load_addr_q <= '0;
        else load_addr_q <= load_addr_q + ADDR_W'(1);
      end

      // stack pointer
      if (cmd_i.start) begin
        sp_q <= start_ok ? (ADDR_W+1)'(1) : '0;
      end else if (cmd_i.pop) begin
        sp_q <= sp_q - (ADDR_W+1)'(1);
      end else if (push) begin
        sp_q <= sp_q + (ADDR_W+1)'(1);
      end

      // sweep counter for clearing pass and final scan
      if (cmd_i.start) begin
        sweep_q <= '0;
      end else if (cmd_i.clr_step || cmd_i.scan_issue) begin
        sweep_q <= sweep_q + (ADDR_W+1)'(1);
      end

      // neighbor direction
      if (cmd_i.pop_latch) begin
        nb_q <= DIR_RIGHT;
      end else if (cmd_i.nb_adv) begin
        nb_q <= dir_e'(2'(nb_q) + 2'd1);
      end

      // scan pipeline and miss count
      scan_vld_q <= cmd_i.scan_issue;
      if (cmd_i.start) begin
        missed_q <= '0;
      end else if (scan_vld_q && cell_rd == KIND_MUST && !vis_rd && missed_q != COUNT_MAX) begin
        missed_q <= missed_q + COUNT_W'(1);
      end

      // result register
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      w_q       <= w_eff;
      h_q       <= h_eff;
      area_m1_q <= (2*DIM_W)'(w_eff) * (2*DIM_W)'(h_eff) - (2*DIM_W)'(1);
    end
    if (cmd_i.pop_latch) begin
      cur_q <= stk_rd;
    end
    if (cmd_i.probe) begin
      pr_q     <= nb_c;
      pr_idx_q <= nb_idx;
    end
    if (cmd_i.scan_issue) begin
      scan_idx_q <= sweep_q[ADDR_W-1:0];
    end
    if (cmd_i.publish) begin
      out_q.all_reachable   <= (missed_q == '0);
      out_q.unreached_count <= missed_q;
    end
  end

  assign status_o.clr_last  = (sweep_q == (ADDR_W+1)'(CELL_TOTAL - 1));
  assign status_o.sp_zero   = (sp_q == '0);
  assign status_o.nb_inb    = nb_inb;
  assign status_o.nb_last   = (nb_q == DIR_UP);
  assign status_o.scan_last = ((2*DIM_W)'(sweep_q) == area_m1_q);
  assign status_o.out_full  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/grid_reachability_fill_unit.sv
// load: one cell per cycle while loading; a cell without the last mark gives no result
// fill: a popped cell probes right, left, down, up; in-grid neighbors are checked
// scan: once the stack is empty, both maps are read for width*height cells,
// then the result is published when the output register is free
// reset: async active low; all 4096 visited-map entries are cleared before cells load
// registers reset to width 64, height 64, start (0, 0)
`default_nettype none

module grid_reachability_fill_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire grf_pkg::cell_in_t                 in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output grf_pkg::result_t                       out_data_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [grf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [grf_pkg::CFG_DAT_W-1:0]     cfg_data_i
);

  import grf_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_width  <= DIM_W'(MAX_COLS);
      cfg_q.map_height <= DIM_W'(MAX_ROWS);
      cfg_q.start_col  <= '0;
      cfg_q.start_row  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAP_WIDTH:  cfg_q.map_width  <= cfg_data_i[DIM_W-1:0];
        CFG_MAP_HEIGHT: cfg_q.map_height <= cfg_data_i[DIM_W-1:0];
        CFG_START_COL:  cfg_q.start_col  <= cfg_data_i[START_W-1:0];
        CFG_START_ROW:  cfg_q.start_row  <= cfg_data_i[START_W-1:0];
        default: begin
        end
      endcase
    end
  end

  grf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_cell),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  grf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // stack is drained whenever cells are being taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> status.sp_zero)
    else $error("fill stack not empty while loading");

  // a new result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> !status.out_full)
    else $error("result published over a pending transaction");

  // flag and count agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.all_reachable == (out_data_o.unreached_count == '0)))
    else $error("all_reachable disagrees with unreached_count");

endmodule

`default_nettype wire
